// ===== hw/rtl/wpf_pkg.sv =====
package wpf_pkg;

   localparam int CoordW = 16;
   localparam int QuatW = 16;
   localparam int RadiusW = 15;
   localparam int SpeedW = 10;
   localparam int AngleW = 16;
   localparam int IndexW = 2;
   localparam int CsrAddrW = 3;
   localparam int CsrDataW = 16;
   localparam int QueueDepth = 2;

   // item kinds
   localparam logic CMD_ODOM = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // register indexes
   localparam logic [CsrAddrW-1:0] REG_WP0_X = 3'd0;
   localparam logic [CsrAddrW-1:0] REG_WP0_Y = 3'd1;
   localparam logic [CsrAddrW-1:0] REG_WP1_X = 3'd2;
   localparam logic [CsrAddrW-1:0] REG_WP1_Y = 3'd3;
   localparam logic [CsrAddrW-1:0] REG_WP2_X = 3'd4;
   localparam logic [CsrAddrW-1:0] REG_WP2_Y = 3'd5;
   localparam logic [CsrAddrW-1:0] REG_RADIUS = 3'd6;
   localparam logic [CsrAddrW-1:0] REG_SPEED = 3'd7;

   localparam logic signed [CoordW-1:0] WP0_X_RST = 16'sd936;
   localparam logic signed [CoordW-1:0] WP0_Y_RST = 16'sd1873;
   localparam logic signed [CoordW-1:0] WP1_X_RST = 16'sd936;
   localparam logic signed [CoordW-1:0] WP1_Y_RST = 16'sd2497;
   localparam logic signed [CoordW-1:0] WP2_X_RST = 16'sd936;
   localparam logic signed [CoordW-1:0] WP2_Y_RST = 16'sd3433;
   localparam logic [RadiusW-1:0] RADIUS_RST = 15'd102;
   localparam logic [SpeedW-1:0] SPEED_RST = 10'd102;

   localparam logic [IndexW-1:0] WP_DONE = 2'd3;

   typedef struct packed {
      logic kind;
      logic signed [CoordW-1:0] odom_x;
      logic signed [CoordW-1:0] odom_y;
      logic signed [QuatW-1:0] quat_x;
      logic signed [QuatW-1:0] quat_y;
      logic signed [QuatW-1:0] quat_z;
      logic signed [QuatW-1:0] quat_w;
   } item_type;

   // arctan(2^-i), 2^31 = pi
   function automatic logic signed [32:0] atan_lut(input logic [3:0] i);
      logic signed [32:0] v;
      begin
         unique case (i)
            4'd0: v = 33'sh020000000;
            4'd1: v = 33'sh012E4051E;
            4'd2: v = 33'sh009FB385B;
            4'd3: v = 33'sh0051111D4;
            4'd4: v = 33'sh0028B0D43;
            4'd5: v = 33'sh00145D7E1;
            4'd6: v = 33'sh000A2F61E;
            4'd7: v = 33'sh000517C55;
            4'd8: v = 33'sh00028BE53;
            4'd9: v = 33'sh000145F2F;
            4'd10: v = 33'sh0000A2F98;
            4'd11: v = 33'sh0000517CC;
            4'd12: v = 33'sh000028BE6;
            4'd13: v = 33'sh0000145F3;
            4'd14: v = 33'sh00000A2FA;
            default: v = 33'sh00000517D;
         endcase
         return v;
      end
   endfunction

endpackage

// ===== hw/rtl/waypoint_heading_follower_top.sv =====
// Go-to-goal heading controller for three waypoints. Odometry beats set the
// position and the heading (yaw from the quaternion by a 16-step CORDIC
// atan2); tick beats return one command, or nothing once all waypoints are
// done. A small input queue takes beats while the sequencer works; one
// shared 18x18 multiplier and the CORDIC unit set the cost. The sequencer
// takes no new beat until it is through with the last; an odometry beat
// whose quaternion gives a zero vector, and a tick that finds the waypoint
// reached, skip the CORDIC steps. Results wait in an output register; a
// tick that finds it full waits until the receiver takes the result.
module waypoint_heading_follower_top #(
   parameter int QDEPTH = wpf_pkg::QueueDepth
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [95:0] req_tdata,  // odom_x, odom_y, quat_x, quat_y, quat_z, quat_w
   input  logic req_tuser,         // cmd
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [31:0] rsp_tdata,  // linear_speed, angular_rate, target_index, zero fill
   output logic rsp_tuser,         // reached
   input  logic csr_we,
   input  logic [wpf_pkg::CsrAddrW-1:0] csr_addr,
   input  logic [wpf_pkg::CsrDataW-1:0] csr_wdata
);
   import wpf_pkg::*;

   logic q_valid, q_pop;
   item_type q_item;

   wpf_front #(.QDEPTH(QDEPTH)) u_front (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .q_valid(q_valid),
      .q_item(q_item),
      .q_pop(q_pop)
   );

   wpf_back u_back (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata),
      .q_valid(q_valid),
      .q_item(q_item),
      .q_pop(q_pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

endmodule

// ===== hw/rtl/wpf_front.sv =====
module wpf_front #(
   parameter int QDEPTH = wpf_pkg::QueueDepth
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [95:0] req_tdata,
   input  logic req_tuser,
   output logic q_valid,
   output wpf_pkg::item_type q_item,
   input  logic q_pop
);
   import wpf_pkg::*;

   localparam int PtrW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int CntW = $clog2(QDEPTH + 1);

   item_type entry_ff [QDEPTH];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0] count_ff;
   item_type item_in;
   logic push, pop;

   // classify the beat and unpack its fields
   always_comb begin
      item_in.kind = req_tuser ? CMD_TICK : CMD_ODOM;
      item_in.odom_x = req_tdata[15:0];
      item_in.odom_y = req_tdata[31:16];
      item_in.quat_x = req_tdata[47:32];
      item_in.quat_y = req_tdata[63:48];
      item_in.quat_z = req_tdata[79:64];
      item_in.quat_w = req_tdata[95:80];
   end

   assign req_tready = (count_ff != CntW'(QDEPTH));
   assign push = req_tvalid && req_tready;
   assign pop = q_pop && q_valid;
   assign q_valid = (count_ff != '0);
   assign q_item = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== hw/rtl/wpf_back.sv =====
module wpf_back (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic [wpf_pkg::CsrAddrW-1:0] csr_addr,
   input  logic [wpf_pkg::CsrDataW-1:0] csr_wdata,
   input  logic q_valid,
   input  wpf_pkg::item_type q_item,
   output logic q_pop,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [31:0] rsp_tdata,
   output logic rsp_tuser
);
   import wpf_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL = 3'd1;
   localparam logic [2:0] S_PRE = 3'd2;
   localparam logic [2:0] S_ITER = 3'd3;
   localparam logic [2:0] S_POST = 3'd4;
   localparam logic [2:0] S_RATE = 3'd5;
   localparam logic [2:0] S_ARR = 3'd6;

   localparam logic signed [17:0] RATE_GAIN = 18'sd38604;
   localparam logic signed [35:0] ONE_Q28 = 36'sd268435456;
   localparam logic signed [32:0] QUARTER = 33'sh040000000;

   logic [2:0] state_ff;
   logic [2:0] step_ff;
   logic [3:0] iter_ff;
   logic [IndexW-1:0] wp_idx_ff;
   logic rsp_valid_ff;

   logic signed [CoordW-1:0] wp0_x_ff, wp0_y_ff, wp1_x_ff, wp1_y_ff, wp2_x_ff, wp2_y_ff;
   logic [RadiusW-1:0] radius_ff;
   logic [SpeedW-1:0] speed_ff;
   logic signed [CoordW-1:0] pos_x_ff, pos_y_ff;
   logic [AngleW-1:0] heading_ff;

   logic kind_ff;
   logic signed [QuatW-1:0] qx_ff, qy_ff, qz_ff, qw_ff;
   logic signed [16:0] dx_ff, dy_ff;
   logic signed [35:0] sacc_ff, cacc_ff, prod_ff;
   logic signed [35:0] cx_ff, cy_ff;
   logic signed [32:0] acc_ff;
   logic eneg_ff;
   logic [SpeedW-1:0] out_speed_ff;
   logic [15:0] out_rate_ff;
   logic [IndexW-1:0] out_idx_ff;
   logic out_reached_ff;

   logic signed [CoordW-1:0] tx, ty;
   logic signed [17:0] mul_a, mul_b;
   logic signed [35:0] product;
   logic signed [35:0] vx, vy, xs, ys;
   logic signed [32:0] acc_rnd;
   logic [AngleW-1:0] angle, err;
   logic [15:0] mag;
   logic [35:0] rate_rnd;
   logic [15:0] rate_abs;
   logic out_free;

   always_comb begin
      case (wp_idx_ff)
         2'd0: begin
            tx = wp0_x_ff;
            ty = wp0_y_ff;
         end
         2'd1: begin
            tx = wp1_x_ff;
            ty = wp1_y_ff;
         end
         default: begin
            tx = wp2_x_ff;
            ty = wp2_y_ff;
         end
      endcase
   end

   assign acc_rnd = acc_ff + 33'sd32768;
   assign angle = acc_rnd[31:16];
   assign err = angle - heading_ff;
   assign mag = err[15] ? (16'd0 - err) : err;

   // one shared multiplier, product registered
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == S_MUL) begin
         if (kind_ff == CMD_ODOM) begin
            case (step_ff)
               3'd0: begin
                  mul_a = 18'(qw_ff);
                  mul_b = 18'(qz_ff);
               end
               3'd1: begin
                  mul_a = 18'(qx_ff);
                  mul_b = 18'(qy_ff);
               end
               3'd2: begin
                  mul_a = 18'(qy_ff);
                  mul_b = 18'(qy_ff);
               end
               3'd3: begin
                  mul_a = 18'(qz_ff);
                  mul_b = 18'(qz_ff);
               end
               default: ;
            endcase
         end else begin
            case (step_ff)
               3'd0: begin
                  mul_a = 18'(dx_ff);
                  mul_b = 18'(dx_ff);
               end
               3'd1: begin
                  mul_a = 18'(dy_ff);
                  mul_b = 18'(dy_ff);
               end
               3'd2: begin
                  mul_a = {3'b000, radius_ff};
                  mul_b = {3'b000, radius_ff};
               end
               default: ;
            endcase
         end
      end else if (state_ff == S_POST) begin
         mul_a = {2'b00, mag};
         mul_b = RATE_GAIN;
      end
   end

   assign product = mul_a * mul_b;

   // vector handed to the atan2 unit
   always_comb begin
      if (kind_ff == CMD_ODOM) begin
         vy = sacc_ff <<< 1;
         vx = ONE_Q28 - (cacc_ff <<< 1);
      end else begin
         vy = 36'(dy_ff);
         vx = 36'(dx_ff);
      end
   end

   assign xs = cx_ff >>> iter_ff;
   assign ys = cy_ff >>> iter_ff;

   assign rate_rnd = 36'(prod_ff) + 36'd32768;
   assign rate_abs = rate_rnd[31:16];

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign q_pop = (state_ff == S_IDLE);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {4'b0000, out_idx_ff, out_rate_ff, out_speed_ff};
   assign rsp_tuser = out_reached_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp0_x_ff <= WP0_X_RST;
         wp0_y_ff <= WP0_Y_RST;
         wp1_x_ff <= WP1_X_RST;
         wp1_y_ff <= WP1_Y_RST;
         wp2_x_ff <= WP2_X_RST;
         wp2_y_ff <= WP2_Y_RST;
         radius_ff <= RADIUS_RST;
         speed_ff <= SPEED_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_WP0_X: wp0_x_ff <= csr_wdata;
            REG_WP0_Y: wp0_y_ff <= csr_wdata;
            REG_WP1_X: wp1_x_ff <= csr_wdata;
            REG_WP1_Y: wp1_y_ff <= csr_wdata;
            REG_WP2_X: wp2_x_ff <= csr_wdata;
            REG_WP2_Y: wp2_y_ff <= csr_wdata;
            REG_RADIUS: radius_ff <= csr_wdata[RadiusW-1:0];
            REG_SPEED: speed_ff <= csr_wdata[SpeedW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      // rate product is held while the command waits for the output register
      if (state_ff != S_RATE) begin
         prod_ff <= product;
      end
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= '0;
         iter_ff <= '0;
         wp_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         heading_ff <= '0;
      end else begin
         if ((state_ff == S_RATE || state_ff == S_ARR) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  kind_ff <= q_item.kind;
                  qx_ff <= q_item.quat_x;
                  qy_ff <= q_item.quat_y;
                  qz_ff <= q_item.quat_z;
                  qw_ff <= q_item.quat_w;
                  dx_ff <= 17'(tx) - 17'(pos_x_ff);
                  dy_ff <= 17'(ty) - 17'(pos_y_ff);
                  step_ff <= '0;
                  if (q_item.kind == CMD_ODOM) begin
                     pos_x_ff <= q_item.odom_x;
                     pos_y_ff <= q_item.odom_y;
                     state_ff <= S_MUL;
                  end else if (wp_idx_ff != WP_DONE) begin
                     state_ff <= S_MUL;
                  end
               end
            end
            S_MUL: begin
               step_ff <= step_ff + 1'b1;
               if (kind_ff == CMD_ODOM) begin
                  case (step_ff)
                     3'd1: sacc_ff <= prod_ff;
                     3'd2: sacc_ff <= sacc_ff + prod_ff;
                     3'd3: cacc_ff <= prod_ff;
                     3'd4: begin
                        cacc_ff <= cacc_ff + prod_ff;
                        state_ff <= S_PRE;
                     end
                     default: ;
                  endcase
               end else begin
                  case (step_ff)
                     3'd1: cacc_ff <= prod_ff;
                     3'd2: cacc_ff <= cacc_ff + prod_ff;
                     // squared distance against squared radius
                     3'd3: state_ff <= (cacc_ff > prod_ff) ? S_PRE : S_ARR;
                     default: ;
                  endcase
               end
            end
            S_PRE: begin
               iter_ff <= '0;
               if (vx == '0 && vy == '0) begin
                  acc_ff <= '0;
                  state_ff <= S_POST;
               end else begin
                  state_ff <= S_ITER;
                  if (vx < 0) begin
                     if (vy >= 0) begin
                        cx_ff <= vy;
                        cy_ff <= -vx;
                        acc_ff <= QUARTER;
                     end else begin
                        cx_ff <= -vy;
                        cy_ff <= vx;
                        acc_ff <= -QUARTER;
                     end
                  end else begin
                     cx_ff <= vx;
                     cy_ff <= vy;
                     acc_ff <= '0;
                  end
               end
            end
            S_ITER: begin
               if (cy_ff > 0) begin
                  cx_ff <= cx_ff + ys;
                  cy_ff <= cy_ff - xs;
                  acc_ff <= acc_ff + atan_lut(iter_ff);
               end else begin
                  cx_ff <= cx_ff - ys;
                  cy_ff <= cy_ff + xs;
                  acc_ff <= acc_ff - atan_lut(iter_ff);
               end
               iter_ff <= iter_ff + 1'b1;
               if (iter_ff == 4'd15) begin
                  state_ff <= S_POST;
               end
            end
            S_POST: begin
               if (kind_ff == CMD_ODOM) begin
                  heading_ff <= angle;
                  state_ff <= S_IDLE;
               end else begin
                  eneg_ff <= err[15];
                  state_ff <= S_RATE;
               end
            end
            S_RATE: begin
               if (out_free) begin
                  out_speed_ff <= speed_ff;
                  out_rate_ff <= eneg_ff ? (16'd0 - rate_abs) : rate_abs;
                  out_idx_ff <= wp_idx_ff;
                  out_reached_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            S_ARR: begin
               if (out_free) begin
                  wp_idx_ff <= wp_idx_ff + 1'b1;
                  out_speed_ff <= '0;
                  out_rate_ff <= '0;
                  out_idx_ff <= wp_idx_ff + 1'b1;
                  out_reached_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== bench/waypoint_heading_follower_checker.sv =====
`timescale 1ns / 1ps

module waypoint_heading_follower_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   input  logic req_tready,
   input  logic [95:0] req_tdata,
   input  logic req_tuser,
   input  logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic rsp_tuser,
   input  logic csr_we,
   input  logic [wpf_pkg::CsrAddrW-1:0] csr_addr,
   input  logic [wpf_pkg::CsrDataW-1:0] csr_wdata,
   output int fail_count,
   output int cmds_pending
);
   import wpf_pkg::*;

   typedef struct {
      logic [SpeedW-1:0] speed;
      logic signed [AngleW-1:0] rate;
      logic [IndexW-1:0] index;
      logic reached;
   } command_type;

   command_type cmd_queue[$];

   longint wp_x[3], wp_y[3];
   longint radius, speed;
   longint pos_x, pos_y;
   logic [AngleW-1:0] heading;
   logic [IndexW-1:0] wp_index;

   longint arctan_steps[16] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
      64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
   };

   function automatic logic [AngleW-1:0] angle_of(longint y, longint x);
      longint acc, t, xs, ys;
      logic [63:0] rounded;
      acc = 0;
      if (x == 0 && y == 0) return '0;
      // quarter-turn into the right half plane
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; acc = 64'sh40000000;
         end else begin
            t = x; x = -y; y = t; acc = -64'sh40000000;
         end
      end
      for (int i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x += ys; y -= xs; acc += arctan_steps[i];
         end else begin
            x -= ys; y += xs; acc -= arctan_steps[i];
         end
      end
      rounded = (acc + 64'h8000) >> 16;
      return rounded[AngleW-1:0];
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
      fail_count++;
   endtask

   task automatic follow_item(input logic kind, input logic [95:0] d);
      longint qx, qy, qz, qw, tx, ty, dx, dy, e, mag, r;
      logic [AngleW-1:0] bearing, diff;
      command_type c;
      if (kind == CMD_ODOM) begin
         qx = $signed(d[47:32]);
         qy = $signed(d[63:48]);
         qz = $signed(d[79:64]);
         qw = $signed(d[95:80]);
         pos_x = $signed(d[15:0]);
         pos_y = $signed(d[31:16]);
         heading = angle_of(2 * (qw * qz + qx * qy),
                            (64'sd1 <<< 28) - 2 * (qy * qy + qz * qz));
         return;
      end
      if (wp_index == WP_DONE) return;
      tx = wp_x[wp_index];
      ty = wp_y[wp_index];
      dx = tx - pos_x;
      dy = ty - pos_y;
      if (dx * dx + dy * dy > radius * radius) begin
         bearing = angle_of(dy, dx);
         diff = bearing - heading;
         e = $signed(diff);
         mag = e < 0 ? -e : e;
         r = (mag * 38604 + 32768) >>> 16;
         if (e < 0) r = -r;
         c.speed = speed[SpeedW-1:0];
         c.rate = r[AngleW-1:0];
         c.index = wp_index;
         c.reached = 1'b0;
      end else begin
         wp_index = wp_index + 1'b1;
         c.speed = '0;
         c.rate = '0;
         c.index = wp_index;
         c.reached = 1'b1;
      end
      cmd_queue.push_back(c);
   endtask

   always @(posedge clock) begin
      command_type want;
      if (reset) begin
         wp_x = '{WP0_X_RST, WP1_X_RST, WP2_X_RST};
         wp_y = '{WP0_Y_RST, WP1_Y_RST, WP2_Y_RST};
         radius = RADIUS_RST;
         speed = SPEED_RST;
         pos_x = 0; pos_y = 0; heading = '0; wp_index = '0;
         cmd_queue.delete();
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (cmd_queue.size() == 0) begin
               report("unexpected command beat", rsp_tdata, 0);
            end else begin
               want = cmd_queue.pop_front();
               if (rsp_tdata[9:0] != want.speed)
                  report("linear_speed", rsp_tdata[9:0], want.speed);
               if (rsp_tdata[25:10] != want.rate)
                  report("angular_rate", $signed(rsp_tdata[25:10]), want.rate);
               if (rsp_tdata[27:26] != want.index)
                  report("target_index", rsp_tdata[27:26], want.index);
               if (rsp_tdata[31:28] != 4'd0)
                  report("tdata fill", rsp_tdata[31:28], 0);
               if (rsp_tuser != want.reached)
                  report("reached", rsp_tuser, want.reached);
            end
         end
         if (req_tvalid && req_tready) follow_item(req_tuser, req_tdata);
         if (csr_we) begin
            case (csr_addr)
               REG_WP0_X: wp_x[0] = $signed(csr_wdata);
               REG_WP0_Y: wp_y[0] = $signed(csr_wdata);
               REG_WP1_X: wp_x[1] = $signed(csr_wdata);
               REG_WP1_Y: wp_y[1] = $signed(csr_wdata);
               REG_WP2_X: wp_x[2] = $signed(csr_wdata);
               REG_WP2_Y: wp_y[2] = $signed(csr_wdata);
               REG_RADIUS: radius = csr_wdata[RadiusW-1:0];
               REG_SPEED: speed = csr_wdata[SpeedW-1:0];
               default: ;
            endcase
         end
      end
      cmds_pending = cmd_queue.size();
   end

endmodule

// ===== bench/waypoint_heading_follower_top_tb.sv =====
`timescale 1ns / 1ps

module waypoint_heading_follower_top_tb;
   import wpf_pkg::*;

   localparam int StallLimit = 20000;
   localparam int Settle = 100;

   logic clock, reset;
   logic req_tvalid, req_tready, req_tuser;
   logic [95:0] req_tdata;
   logic rsp_tvalid, rsp_tready, rsp_tuser;
   logic [31:0] rsp_tdata;
   logic csr_we;
   logic [CsrAddrW-1:0] csr_addr;
   logic [CsrDataW-1:0] csr_wdata;
   int fail_count, cmds_pending;
   int idle_cycles;
   bit calm, hold_rsp;

   waypoint_heading_follower_top u_top (.*);

   waypoint_heading_follower_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog over cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else if (idle_cycles >= StallLimit) begin
         $display("== FAIL ==");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // command receiver: random stall bursts, one long hold-off on request
   initial begin
      bit held;
      held = 1'b0;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp && !held) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   function automatic logic [95:0] odom_beat(logic [15:0] px, logic [15:0] py,
         logic [15:0] qx, logic [15:0] qy, logic [15:0] qz, logic [15:0] qw);
      return {qw, qz, qy, qx, py, px};
   endfunction

   task automatic send(input logic kind, input logic [95:0] d);
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task automatic tick();
      send(CMD_TICK, {$urandom, $urandom, $urandom});
   endtask

   task automatic odom(input logic [15:0] px, input logic [15:0] py,
         input logic [15:0] qx, input logic [15:0] qy,
         input logic [15:0] qz, input logic [15:0] qw);
      send(CMD_ODOM, odom_beat(px, py, qx, qy, qz, qw));
   endtask

   function automatic logic [15:0] quat_part();
      if ($urandom_range(0, 3) == 0) return 16'($urandom);
      return 16'($urandom_range(0, 32768) - 16384);
   endfunction

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (cmds_pending != 0) @(posedge clock);
      repeat (Settle) @(posedge clock);
   endtask

   task automatic write_regs(input logic [15:0] v[8]);
      for (int i = 0; i < 8; i++) begin
         csr_we <= 1'b1;
         csr_addr <= CsrAddrW'(i);
         csr_wdata <= v[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic random_items(input int count, input int tick_pct);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < tick_pct) tick();
         else odom(16'($urandom), 16'($urandom), quat_part(), quat_part(),
                   quat_part(), quat_part());
      end
   endtask

   initial begin
      logic [15:0] regs[8];
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = CMD_ODOM;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_addr = REG_WP0_X;
      csr_wdata = '0;
      calm = 1'b0;
      hold_rsp = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: reset waypoints, field extremes, zero quaternion
      tick();
      odom(16'h8000, 16'h7FFF, 16'd0, 16'd0, 16'd0, 16'd0);
      tick();
      odom(16'h7FFF, 16'h8000, 16'd16384, 16'd0, 16'd0, 16'd0);
      tick();
      odom(16'd0, 16'd0, 16'd0, 16'd0, 16'd16384, 16'd0);
      tick();
      odom(16'hFFFF, 16'h0001, 16'hC000, 16'hC000, 16'hC000, 16'hC000);
      tick();
      odom(16'h1234, 16'hEDCB, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF);
      tick();
      odom(16'd0, 16'd0, 16'd0, 16'd0, 16'd11585, 16'hD2BF);
      tick();
      drain();

      // waypoint straight behind: heading error of exactly minus pi
      regs = '{16'hFC18, 16'd0, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
               16'd0, 16'd1023};
      write_regs(regs);
      odom(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd16384);
      tick();
      odom(16'h7FFF, 16'h0000, 16'd0, 16'd0, 16'd0, 16'd16384);
      tick();
      odom(16'h8000, 16'h7FFF, 16'd0, 16'd0, 16'd0, 16'd16384);
      tick();
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         foreach (regs[i]) regs[i] = 16'($urandom);
         regs[REG_RADIUS] = (phase == 0) ? 16'd0 : 16'($urandom_range(0, 600));
         regs[REG_SPEED] = (phase == 1) ? 16'd0 : 16'($urandom);
         write_regs(regs);
         random_items(120, 50);
         if (phase == 2) hold_rsp = 1'b1;
         random_items(120, 60);
         drain();
      end

      // wide radius, then walk onto each waypoint
      calm = 1'b1;
      regs = '{16'd500, 16'd500, 16'hFE00, 16'd1000, 16'h7FFF, 16'h8000,
               16'h7FFF, 16'd1023};
      write_regs(regs);
      odom(16'h8000, 16'h7FFF, quat_part(), quat_part(), quat_part(), quat_part());
      tick();
      regs[REG_RADIUS] = 16'd200;
      drain();
      write_regs(regs);
      for (int w = 0; w < 3; w++) begin
         odom(16'h4000, 16'h4000, quat_part(), quat_part(), quat_part(),
              quat_part());
         tick();
         odom(regs[2 * w] + 16'd100, regs[2 * w + 1] - 16'd100, quat_part(),
              quat_part(), quat_part(), quat_part());
         tick();
      end
      random_items(30, 70);
      drain();

      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
